// ===== design/jsj_pkg.sv =====
`timescale 1ns / 1ps

package jsj_pkg;

  // fixed formats
  localparam int Q_BITS      = 16;
  localparam int MAG_W       = Q_BITS + 1;
  localparam int DEFL_W      = MAG_W + 1;
  localparam int POS_W       = 11;
  localparam int DIV_STEPS   = Q_BITS;
  localparam int DIV_CNT_W   = $clog2(DIV_STEPS);
  localparam int RANGE_W     = 9;
  localparam int CENTER_W    = 10;
  localparam int CURVE_BIG_W = 330;
  localparam int CURVE_NUM   = 13;
  localparam int CURVE_DEN   = 10;
  localparam int SEARCH_ITER = 18;

  localparam logic [MAG_W-1:0] Q16_ONE  = MAG_W'(1 << Q_BITS);
  localparam int               Q16_HALF = 1 << (Q_BITS - 1);

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_CENTER    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DEAD_ZONE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RANGE     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_POS_MIN   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_POS_MAX   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_HOME      = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SLEW_RATE = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_LEAD  = 3'd7;

  localparam logic [CENTER_W-1:0]   CENTER_RST    = 10'd512;
  localparam logic [7:0]            DEAD_ZONE_RST = 8'd25;
  localparam logic [RANGE_W-1:0]    RANGE_RST     = 9'd438;
  localparam logic [7:0]            POS_MIN_RST   = 8'd5;
  localparam logic [7:0]            POS_MAX_RST   = 8'd175;
  localparam logic [7:0]            HOME_RST      = 8'd90;
  localparam logic [Q_BITS-1:0]     SLEW_RATE_RST = 16'd1638;
  localparam logic [7:0]            MAX_LEAD_RST  = 8'd5;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_DIV,
    ST_MUL,
    ST_ROM,
    ST_TGT,
    ST_SLEW,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic                 start;
    logic [RANGE_W-1:0]   num;
    logic [RANGE_W-1:0]   den;
  } div_req_t;

  typedef struct packed {
    logic                 done;
    logic [Q_BITS-1:0]    quot;
  } div_rsp_t;

  typedef logic signed [POS_W-1:0] pos_t;

  function automatic pos_t clamp_pos(input pos_t x, input pos_t lo, input pos_t hi);
    pos_t r;
    if (x < lo) begin
      r = lo;
    end else if (x > hi) begin
      r = hi;
    end else begin
      r = x;
    end
    return r;
  endfunction

  function automatic logic [7:0] sat_byte(input pos_t x);
    logic [7:0] r;
    if (x < 0) begin
      r = 8'd0;
    end else if (x > 255) begin
      r = 8'd255;
    end else begin
      r = x[7:0];
    end
    return r;
  endfunction

  // largest y in [0, 1.0] with y^10 * last^13 <= 2^160 * k^13
  function automatic logic [MAG_W-1:0] curve_entry(input int k, input int last);
    logic [CURVE_BIG_W-1:0] rhs;
    logic [CURVE_BIG_W-1:0] lhs;
    logic [CURVE_BIG_W-1:0] lp;
    logic [MAG_W:0]         lo;
    logic [MAG_W:0]         hi;
    logic [MAG_W:0]         mid;
    rhs = CURVE_BIG_W'(1);
    lp  = CURVE_BIG_W'(1);
    for (int i = 0; i < CURVE_NUM; i++) begin
      rhs = rhs * CURVE_BIG_W'(k);
      lp  = lp * CURVE_BIG_W'(last);
    end
    rhs = rhs << (CURVE_DEN * Q_BITS);
    lo  = '0;
    hi  = (MAG_W + 1)'(Q16_ONE);
    for (int it = 0; it < SEARCH_ITER; it++) begin
      if (lo < hi) begin
        mid = (lo + hi + 1'b1) >> 1;
        lhs = lp;
        for (int j = 0; j < CURVE_DEN; j++) begin
          lhs = lhs * CURVE_BIG_W'(mid);
        end
        if (lhs <= rhs) begin
          lo = mid;
        end else begin
          hi = mid - 1'b1;
        end
      end
    end
    return lo[MAG_W-1:0];
  endfunction

endpackage

// ===== design/jsj_curve_rom.sv =====
`timescale 1ns / 1ps

module jsj_curve_rom #(
  parameter int ENTRIES = 1024
) (
  input  logic                             clk,
  input  logic [$clog2(ENTRIES)-1:0]       addr,
  output logic [jsj_pkg::MAG_W-1:0]        data
);

  logic [jsj_pkg::MAG_W-1:0] tab [ENTRIES];
  logic [jsj_pkg::MAG_W-1:0] data_r;

  for (genvar k = 0; k < ENTRIES; k++) begin : g_tab
    localparam logic [jsj_pkg::MAG_W-1:0] Val = jsj_pkg::curve_entry(k, ENTRIES - 1);
    assign tab[k] = Val;
  end

  always_ff @(posedge clk) begin
    data_r <= tab[addr];
  end

  assign data = data_r;

endmodule

// ===== design/jsj_div.sv =====
`timescale 1ns / 1ps

// restoring divider, one quotient bit per cycle, num < den
module jsj_div (
  input  logic                clk,
  input  logic                rst_n,
  input  jsj_pkg::div_req_t   req,
  output jsj_pkg::div_rsp_t   rsp
);

  localparam int RW = jsj_pkg::RANGE_W;
  localparam int QW = jsj_pkg::Q_BITS;
  localparam int CW = jsj_pkg::DIV_CNT_W;

  logic          busy_r;
  logic          done_r;
  logic [CW-1:0] cnt_r;
  logic [RW-1:0] rem_r;
  logic [RW-1:0] den_r;
  logic [QW-1:0] quot_r;
  logic [RW:0]   trial;
  logic          fits;

  assign trial = {rem_r, 1'b0};
  assign fits  = trial >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CW'(jsj_pkg::DIV_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r  <= req.num;
      den_r  <= req.den;
      quot_r <= '0;
    end else if (busy_r) begin
      rem_r  <= fits ? RW'(trial - {1'b0, den_r}) : trial[RW-1:0];
      quot_r <= {quot_r[QW-2:0], fits};
    end
  end

  assign rsp.done = done_r;
  assign rsp.quot = quot_r;

endmodule

// ===== design/joystick_servo_jog_slew.sv =====
`timescale 1ns / 1ps

// joystick jog with dead zone, x^1.3 shaping and servo slew limiting
// input channel: one item per control tick (sample, sample_fresh); a fresh
//   sample replaces the held reading, otherwise the held one is reused
// result channel: one item per input item with the signed Q16 deflection,
//   the target angle, the current angle after this tick and a moved flag
// configuration: cfg_we writes cfg_wdata to register cfg_index; the user
//   must make writes only while the block is idle, which it does not enforce
// sequence: an accepted item passes through the prep, div, mul, rom, tgt,
//   slew and out states; the 16-step serial divider runs in div only when the
//   reading lies in the live band below full deflection, and readings in the
//   dead zone or at full deflection skip it
// throughput: one item at a time; in_stall stays high from accept until the
//   result is loaded into the output register
// the output register holds a finished item while out_stall is high; the
//   next item then waits in the out state and no new item is accepted
// reset: registers take their defaults, held sample goes to 512, both
//   angles go to the home position and both fractions clear
module joystick_servo_jog_slew #(
  parameter int SAMPLE_BITS   = 10,
  parameter int CURVE_ENTRIES = 1024,
  parameter int FRACTION_BITS = 16
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     in_valid,
  output logic                                     in_stall,
  input  logic [SAMPLE_BITS-1:0]                   in_sample,
  input  logic                                     in_sample_fresh,
  output logic                                     out_valid,
  input  logic                                     out_stall,
  output logic signed [jsj_pkg::DEFL_W-1:0]        out_deflection,
  output logic [7:0]                               out_target_position,
  output logic [7:0]                               out_current_position,
  output logic                                     out_moved,
  input  logic                                     cfg_we,
  input  logic [jsj_pkg::CFG_IDX_W-1:0]            cfg_index,
  input  logic [jsj_pkg::CFG_DATA_W-1:0]           cfg_wdata
);

  localparam int HW  = (SAMPLE_BITS > jsj_pkg::CENTER_W) ? SAMPLE_BITS : jsj_pkg::CENTER_W;
  localparam int IW  = $clog2(CURVE_ENTRIES);
  localparam int MW  = jsj_pkg::MAG_W;
  localparam int QB  = jsj_pkg::Q_BITS;
  localparam int PW  = MW + IW + 1;
  localparam int FB  = FRACTION_BITS;
  localparam int PSW = jsj_pkg::POS_W;
  localparam logic [IW-1:0] CurveLast = IW'(CURVE_ENTRIES - 1);

  jsj_pkg::state_t state_r, state_nxt;

  // configuration
  logic [jsj_pkg::CENTER_W-1:0] center_r;
  logic [7:0]                   dead_zone_r;
  logic [jsj_pkg::RANGE_W-1:0]  range_r;
  logic [7:0]                   pos_min_r;
  logic [7:0]                   pos_max_r;
  logic [QB-1:0]                slew_rate_r;
  logic [7:0]                   max_lead_r;

  // state
  logic [HW-1:0] held_r;
  logic [7:0]    target_r, target_nxt;
  logic [7:0]    current_r, current_nxt;
  logic [FB-1:0] tfrac_r, tfrac_nxt;
  logic [FB-1:0] sfrac_r, sfrac_nxt;

  // work registers
  logic                       neg_r;
  logic                       live_r;
  logic [MW-1:0]              f_r;
  logic [IW-1:0]              idx_r;
  logic signed [MW:0]         defl_r;
  logic                       moved_r;

  // output register
  logic                       out_valid_r;
  logic signed [MW:0]         out_defl_r;
  logic [7:0]                 out_target_r;
  logic [7:0]                 out_current_r;
  logic                       out_moved_r;

  // front end
  logic                       neg_w;
  logic [HW-1:0]              absd_w;
  logic [HW-1:0]              excess_w;
  logic                       live_w;
  logic [jsj_pkg::RANGE_W-1:0] range_eff;
  logic                       sat_w;

  jsj_pkg::div_req_t div_req;
  jsj_pkg::div_rsp_t div_rsp;
  logic              div_start;

  logic [PW-1:0]              prod_w;
  logic [PW-QB-1:0]           idx_full;
  logic [MW-1:0]              rom_q;
  logic [MW-1:0]              mag_w;
  logic [FB+QB:0]             tf_wide;
  logic [FB+QB-1:0]           sf_wide;
  logic [FB:0]                tsum;
  logic [FB:0]                ssum;
  jsj_pkg::pos_t              tgt_s, cur_s, pmin_s, pmax_s, lead_s;
  jsj_pkg::pos_t              tstep, tclamp, delta, absdist, sstep;
  logic                       load_out;

  assign neg_w     = held_r < HW'(center_r);
  assign absd_w    = neg_w ? HW'(center_r) - held_r : held_r - HW'(center_r);
  assign live_w    = absd_w > HW'(dead_zone_r);
  assign excess_w  = absd_w - HW'(dead_zone_r);
  assign range_eff = (range_r == '0) ? jsj_pkg::RANGE_W'(1) : range_r;
  assign sat_w     = excess_w >= HW'(range_eff);

  assign div_req.start = div_start;
  assign div_req.num   = excess_w[jsj_pkg::RANGE_W-1:0];
  assign div_req.den   = range_eff;

  jsj_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign prod_w   = PW'(f_r) * PW'(CurveLast) + PW'(jsj_pkg::Q16_HALF);
  assign idx_full = prod_w[PW-1:QB];

  jsj_curve_rom #(
    .ENTRIES (CURVE_ENTRIES)
  ) u_rom (
    .clk  (clk),
    .addr (idx_r),
    .data (rom_q)
  );

  // target accumulation and clamping
  assign mag_w   = live_r ? rom_q : '0;
  assign tf_wide = {mag_w, {FB{1'b0}}};
  assign tsum    = {1'b0, tfrac_r} + tf_wide[FB+QB:QB];
  assign tgt_s   = jsj_pkg::pos_t'({3'b000, target_r});
  assign cur_s   = jsj_pkg::pos_t'({3'b000, current_r});
  assign pmin_s  = jsj_pkg::pos_t'({3'b000, pos_min_r});
  assign pmax_s  = jsj_pkg::pos_t'({3'b000, pos_max_r});
  assign lead_s  = jsj_pkg::pos_t'({3'b000, max_lead_r});
  assign tstep   = neg_r ? tgt_s - PSW'(1) : tgt_s + PSW'(1);
  assign tclamp  = jsj_pkg::clamp_pos(jsj_pkg::clamp_pos(tstep, pmin_s, pmax_s),
                                      cur_s - lead_s, cur_s + lead_s);

  always_comb begin
    target_nxt = target_r;
    tfrac_nxt  = tfrac_r;
    if (mag_w != '0) begin
      tfrac_nxt = tsum[FB-1:0];
      if (tsum[FB]) begin
        target_nxt = jsj_pkg::sat_byte(tclamp);
      end
    end
  end

  // slewing
  assign sf_wide = {slew_rate_r, {FB{1'b0}}};
  assign ssum    = {1'b0, sfrac_r} + {1'b0, sf_wide[FB+QB-1:QB]};
  assign delta   = tgt_s - cur_s;
  assign absdist = delta[PSW-1] ? -delta : delta;
  assign sstep   = delta[PSW-1] ? cur_s - PSW'(1) : cur_s + PSW'(1);

  always_comb begin
    current_nxt = current_r;
    sfrac_nxt   = sfrac_r;
    if (absdist <= PSW'(1)) begin
      sfrac_nxt = '0;
    end else begin
      sfrac_nxt = ssum[FB-1:0];
      if (ssum[FB]) begin
        current_nxt = jsj_pkg::sat_byte(jsj_pkg::clamp_pos(sstep, pmin_s, pmax_s));
      end
    end
  end

  // sequencer
  assign load_out = (state_r == jsj_pkg::ST_OUT) && (!out_valid_r || !out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= jsj_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    in_stall  = 1'b1;
    div_start = 1'b0;
    case (state_r)
      jsj_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          state_nxt = jsj_pkg::ST_PREP;
        end
      end
      jsj_pkg::ST_PREP: begin
        if (live_w && !sat_w) begin
          div_start = 1'b1;
          state_nxt = jsj_pkg::ST_DIV;
        end else begin
          state_nxt = jsj_pkg::ST_MUL;
        end
      end
      jsj_pkg::ST_DIV: begin
        if (div_rsp.done) begin
          state_nxt = jsj_pkg::ST_MUL;
        end
      end
      jsj_pkg::ST_MUL:  state_nxt = jsj_pkg::ST_ROM;
      jsj_pkg::ST_ROM:  state_nxt = jsj_pkg::ST_TGT;
      jsj_pkg::ST_TGT:  state_nxt = jsj_pkg::ST_SLEW;
      jsj_pkg::ST_SLEW: state_nxt = jsj_pkg::ST_OUT;
      jsj_pkg::ST_OUT: begin
        if (load_out) begin
          state_nxt = jsj_pkg::ST_IDLE;
        end
      end
      default: state_nxt = jsj_pkg::ST_IDLE;
    endcase
  end

  // configuration and persistent state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_r    <= jsj_pkg::CENTER_RST;
      dead_zone_r <= jsj_pkg::DEAD_ZONE_RST;
      range_r     <= jsj_pkg::RANGE_RST;
      pos_min_r   <= jsj_pkg::POS_MIN_RST;
      pos_max_r   <= jsj_pkg::POS_MAX_RST;
      slew_rate_r <= jsj_pkg::SLEW_RATE_RST;
      max_lead_r  <= jsj_pkg::MAX_LEAD_RST;
      held_r      <= HW'(jsj_pkg::CENTER_RST);
      target_r    <= jsj_pkg::HOME_RST;
      current_r   <= jsj_pkg::HOME_RST;
      tfrac_r     <= '0;
      sfrac_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          jsj_pkg::REG_CENTER:    center_r    <= cfg_wdata[jsj_pkg::CENTER_W-1:0];
          jsj_pkg::REG_DEAD_ZONE: dead_zone_r <= cfg_wdata[7:0];
          jsj_pkg::REG_RANGE:     range_r     <= cfg_wdata[jsj_pkg::RANGE_W-1:0];
          jsj_pkg::REG_POS_MIN:   pos_min_r   <= cfg_wdata[7:0];
          jsj_pkg::REG_POS_MAX:   pos_max_r   <= cfg_wdata[7:0];
          // home position only matters at reset
          jsj_pkg::REG_HOME:      ;
          jsj_pkg::REG_SLEW_RATE: slew_rate_r <= cfg_wdata[QB-1:0];
          jsj_pkg::REG_MAX_LEAD:  max_lead_r  <= cfg_wdata[7:0];
          default: ;
        endcase
      end
      if (state_r == jsj_pkg::ST_IDLE && in_valid && in_sample_fresh) begin
        held_r <= HW'(in_sample);
      end
      if (state_r == jsj_pkg::ST_TGT) begin
        target_r <= target_nxt;
        tfrac_r  <= tfrac_nxt;
      end
      if (state_r == jsj_pkg::ST_SLEW) begin
        current_r <= current_nxt;
        sfrac_r   <= sfrac_nxt;
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // work and output payload
  always_ff @(posedge clk) begin
    case (state_r)
      jsj_pkg::ST_PREP: begin
        neg_r  <= neg_w;
        live_r <= live_w;
        f_r    <= (live_w && sat_w) ? jsj_pkg::Q16_ONE : '0;
      end
      jsj_pkg::ST_DIV: begin
        if (div_rsp.done) begin
          f_r <= {1'b0, div_rsp.quot};
        end
      end
      jsj_pkg::ST_MUL: begin
        idx_r <= (idx_full > (PW - QB)'(CurveLast)) ? CurveLast : idx_full[IW-1:0];
      end
      jsj_pkg::ST_TGT: begin
        defl_r <= neg_r ? -$signed({1'b0, mag_w}) : $signed({1'b0, mag_w});
      end
      jsj_pkg::ST_SLEW: begin
        moved_r <= current_nxt != current_r;
      end
      default: ;
    endcase
    if (load_out) begin
      out_defl_r    <= defl_r;
      out_target_r  <= target_r;
      out_current_r <= current_r;
      out_moved_r   <= moved_r;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_deflection       = out_defl_r;
  assign out_target_position  = out_target_r;
  assign out_current_position = out_current_r;
  assign out_moved            = out_moved_r;

endmodule
